[hw/rtl/tile_dedup_dictionary_defines.svh]
// Assertion macros used by the tile deduplication search engine.
`ifndef TILE_DEDUP_DICTIONARY_DEFINES_SVH
`define TILE_DEDUP_DICTIONARY_DEFINES_SVH

// Concurrent check on the rising clock, off while reset is high.
`define TDD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Concurrent check on the rising clock that also holds during reset.
`define TDD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[hw/rtl/tdd_pkg.sv]
// Shared constants, types and the display code function of the tile dictionary.
package tdd_pkg;

   localparam int TABLE_DEPTH   = 96;
   localparam int TILES_PER_ROW = 12;
   localparam int COL_OFFSET    = 4;
   localparam int NUM_W         = 7;
   localparam int WORD_W        = 64;
   localparam int TILE_W        = 4 * WORD_W;
   localparam int RSP_W         = 24;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   // allocation can never pass the table size nor the entry counter range
   localparam int LIMIT_CAP = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
   localparam int CNT_W     = $clog2(LIMIT_CAP + 1);
   localparam int ADDR_W    = (LIMIT_CAP > 1) ? $clog2(LIMIT_CAP) : 1;

   // row = n / TILES_PER_ROW as (n * ROW_RECIP) >> ROW_RECIP_SHIFT, exact for any NUM_W-bit n
   localparam int ROW_RECIP_SHIFT = 11;
   localparam int ROW_RECIP_W     = ROW_RECIP_SHIFT + 1;
   localparam int ROW_RECIP       = (2**ROW_RECIP_SHIFT + TILES_PER_ROW - 1) / TILES_PER_ROW;

   localparam logic [NUM_W-1:0] TILE_LIMIT_RESET = NUM_W'(96);

   // register index codes (index = byte address / 4)
   localparam logic REG_TILE_LIMIT = 1'b0;

   typedef logic [TILE_W-1:0] tile_type;

   typedef struct packed {
      logic     valid;
      tile_type tile;
   } queue_head_type;

   function automatic logic [NUM_W-1:0] display_code(input logic [NUM_W-1:0] n);
      logic [NUM_W+ROW_RECIP_W-1:0] prod;
      logic [NUM_W-1:0]             row;
      logic [NUM_W-1:0]             col;
      logic [NUM_W+3:0]             code_wide;
      prod      = (NUM_W + ROW_RECIP_W)'(n) * (NUM_W + ROW_RECIP_W)'(ROW_RECIP);
      row       = NUM_W'(prod >> ROW_RECIP_SHIFT);
      col       = n - NUM_W'(row * NUM_W'(TILES_PER_ROW));
      code_wide = {row, 4'b0000} | (NUM_W + 4)'(col + NUM_W'(COL_OFFSET));
      return code_wide[NUM_W-1:0];
   endfunction

endpackage

[hw/rtl/tdd_front.sv]
// Front end: accepts tile beats into a two-entry queue ahead of the search engine.
module tdd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rows_zero_one [63:0], rows_two_three [127:64],
   // rows_four_five [191:128], rows_six_seven [255:192]
   input  logic [tdd_pkg::TILE_W-1:0] req_tdata,
   output tdd_pkg::queue_head_type head,
   input  logic                   pop
);
   import tdd_pkg::*;

   tile_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              take;

   assign req_tready = (count_ff < QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign take       = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.tile  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_tdata;
      end
   end

endmodule

[hw/rtl/tdd_search.sv]
// Back end: scans the tile store one entry per cycle, allocates or overflows, holds the result.
`include "tile_dedup_dictionary_defines.svh"

module tdd_search (
   input  logic                          clock,
   input  logic                          reset,
   input  tdd_pkg::queue_head_type       head,
   output logic                          pop,
   input  logic [tdd_pkg::NUM_W-1:0]     tile_limit,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tile_code [6:0], tile_number [13:7], is_new [14], overflowed_now [15],
   // overflow_seen [16], zero [23:17]
   output logic [tdd_pkg::RSP_W-1:0]     rsp_tdata
);
   import tdd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   tile_type mem [LIMIT_CAP];

   logic [1:0]       state_ff, state_in;
   tile_type         tile_ff;
   tile_type         rd_data_ff;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] cmp_idx_ff;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [NUM_W-1:0] used_ff, used_in;
   logic             overflow_ff, overflow_in;
   logic [NUM_W-1:0] number_ff, number_in;
   logic             new_ff, new_in;
   logic             over_now_ff, over_now_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [NUM_W-1:0] alloc_limit;
   logic             issue;
   logic             hit;
   logic             mem_we;
   logic             load_rsp;

   assign alloc_limit = (tile_limit > NUM_W'(LIMIT_CAP)) ? NUM_W'(LIMIT_CAP) : tile_limit;
   assign issue       = (state_ff == ST_SCAN) && (scan_ff < CNT_W'(used_ff));
   assign hit         = cmp_valid_ff && (rd_data_ff == tile_ff);
   assign load_rsp    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   // search sequencer
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      cmp_valid_in = 1'b0;
      used_in      = used_ff;
      overflow_in  = overflow_ff;
      number_in    = number_ff;
      new_in       = new_ff;
      over_now_in  = over_now_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_valid_in = issue;
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (hit) begin
               cmp_valid_in = 1'b0;
               number_in    = NUM_W'(cmp_idx_ff);
               new_in       = 1'b0;
               over_now_in  = 1'b0;
               state_in     = ST_DONE;
            end else if (!cmp_valid_ff && !issue) begin
               // nothing stored matched
               if (used_ff >= alloc_limit) begin
                  number_in   = '0;
                  new_in      = 1'b0;
                  over_now_in = 1'b1;
                  overflow_in = 1'b1;
               end else begin
                  mem_we      = 1'b1;
                  number_in   = used_ff;
                  new_in      = 1'b1;
                  over_now_in = 1'b0;
                  used_in     = used_ff + 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({overflow_ff, over_now_ff, new_ff, number_ff,
                                display_code(number_ff)});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
         used_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         used_ff      <= used_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (pop) begin
         tile_ff <= head.tile;
      end
      scan_ff     <= scan_in;
      cmp_idx_ff  <= scan_ff;
      number_ff   <= number_in;
      new_ff      <= new_in;
      over_now_ff <= over_now_in;
      rsp_data_ff <= rsp_data_in;
   end

   // tile store: one tile per row, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[used_ff[ADDR_W-1:0]] <= tile_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[scan_ff[ADDR_W-1:0]];
      end
   end

   `TDD_ASSERT(a_used_in_range, used_ff <= NUM_W'(LIMIT_CAP),
      "entry count ran past the table")
   `TDD_ASSERT(a_new_xor_over, rsp_valid_ff |-> !(rsp_data_ff[14] && rsp_data_ff[15]),
      "result both allocated and overflowed")
   `TDD_ASSERT(a_overflow_sticky, ($past(overflow_ff) && !$past(reset)) |-> overflow_ff,
      "overflow flag cleared outside reset")
   `TDD_ASSERT(a_pop_only_idle, pop |-> (state_ff == ST_IDLE && head.valid),
      "queue popped while a search was running")

endmodule

[hw/rtl/tile_dedup_dictionary.sv]
// Top level of the tile deduplication dictionary: register port, front queue and search engine.
//
// Usage:
//   req_* carries one 8x8 tile of 4-bit pixels per beat (256 bits, four 64-bit rows pairs).
//   rsp_* returns one beat per tile: display code, entry number, new/overflow flags and
//   the sticky overflow flag. Results come back in input order.
//   csr_* is an APB-style port; tile_limit sits at byte address 0 (reset 96).
//   Write it only while no tile is in flight.
// Search:
//   The search engine reads the tile store one entry per cycle through its single
//   registered read port and stops at the first match; it scans the entries stored
//   so far (at most 96) and handles one tile at a time, popping the next only after
//   the result of the last is loaded into the output register.
//   The front queue holds two tiles, so req_tready stays high until two tiles wait.
// Reset:
//   Synchronous, active high. Clears the entry count, the overflow flag, the queue and
//   the output register; stored tiles are not cleared and are never read before written.
// Back-pressure:
//   A held result waits in the output register; the engine stalls in its final state
//   until that register frees, and the queue keeps taking tiles until it is full.
module tile_dedup_dictionary (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rows_zero_one [63:0], rows_two_three [127:64],
   // rows_four_five [191:128], rows_six_seven [255:192]
   input  logic [tdd_pkg::TILE_W-1:0]        req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tile_code [6:0], tile_number [13:7], is_new [14], overflowed_now [15],
   // overflow_seen [16], zero [23:17]
   output logic [tdd_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tdd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tdd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tdd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import tdd_pkg::*;

   logic [NUM_W-1:0] tile_limit_ff, tile_limit_in;
   logic             csr_wr;
   logic             sel_limit;
   queue_head_type   head;
   logic             pop;

   // register access
   assign csr_pready = 1'b1;
   assign sel_limit  = (csr_paddr[CSR_ADDR_W-1] == REG_TILE_LIMIT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = sel_limit ? CSR_DATA_W'(tile_limit_ff) : '0;

   always_comb begin
      tile_limit_in = tile_limit_ff;
      if (csr_wr && sel_limit) begin
         tile_limit_in = csr_pwdata[NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_limit_ff <= TILE_LIMIT_RESET;
      end else begin
         tile_limit_ff <= tile_limit_in;
      end
   end

   tdd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (head),
      .pop        (pop)
   );

   tdd_search u_search (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .tile_limit (tile_limit_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[test/tile_dedup_dictionary_test.sv]
// Testbench for the tile dictionary: directed and random tile streams checked against a scoreboard.
`timescale 1ns / 1ps

module tile_dedup_dictionary_test;
   import tdd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600_000;
   localparam int unsigned RANDOM_PHASE_TILES = 100;
   localparam int unsigned LONG_HOLD_AT = 150;
   localparam int unsigned LONG_HOLD_CYCLES = 500;
   localparam int unsigned USED_CAP = 127;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(REG_TILE_LIMIT) << 2;

   // one result beat, laid out as in rsp_tdata[16:0]
   typedef struct packed {
      logic             seen;
      logic             overflowed;
      logic             is_new;
      logic [NUM_W-1:0] number;
      logic [NUM_W-1:0] code;
   } tile_answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // rows_zero_one [63:0], rows_two_three [127:64],
   // rows_four_five [191:128], rows_six_seven [255:192]
   logic [TILE_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tile_code [6:0], tile_number [13:7], is_new [14], overflowed_now [15],
   // overflow_seen [16], zero [23:17]
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // dictionary shadow: stored tiles, fill count, sticky overflow, limit register
   tile_type         stored_tiles [TABLE_DEPTH];
   int unsigned      stored_count = 0;
   bit               overflow_sticky = 1'b0;
   logic [NUM_W-1:0] limit_now = TILE_LIMIT_RESET;

   tile_type         tiles_pending [$];
   tile_type         tile_pool [$];
   tile_answer_type  expected_answers [$];
   tile_answer_type  answer_due;
   tile_answer_type  answer_seen;
   int unsigned      tiles_issued = 0;
   int unsigned      tiles_accepted = 0;
   int unsigned      answers_checked = 0;
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      req_gap_left = 0;
   int unsigned      req_steady_left = 0;
   int unsigned      rsp_hold_left = 0;
   int unsigned      rsp_steady_left = 0;
   bit               long_hold_done = 1'b0;

   tile_dedup_dictionary u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Search the shadow table in entry order; allocate or overflow on a miss.
   function automatic tile_answer_type lookup_tile(input tile_type tile);
      tile_answer_type answer;
      int unsigned     searched;
      int unsigned     alloc_cap;
      int unsigned     e;
      int unsigned     n;
      bit              found;
      answer = '0;
      found = 1'b0;
      searched = (stored_count > TABLE_DEPTH) ? TABLE_DEPTH : stored_count;
      for (e = 0; e < searched && !found; e++) begin
         if (stored_tiles[e] === tile) begin
            found = 1'b1;
            answer.number = NUM_W'(e);
         end
      end
      if (!found) begin
         alloc_cap = limit_now;
         if (alloc_cap > TABLE_DEPTH) alloc_cap = TABLE_DEPTH;
         if (alloc_cap > USED_CAP) alloc_cap = USED_CAP;
         if (stored_count >= alloc_cap) begin
            answer.number = '0;
            answer.overflowed = 1'b1;
            overflow_sticky = 1'b1;
         end else begin
            stored_tiles[stored_count] = tile;
            answer.number = NUM_W'(stored_count);
            answer.is_new = 1'b1;
            stored_count = (stored_count + 1) & USED_CAP;
         end
      end
      // row in the upper three bits, column plus offset in the low nibble
      n = answer.number;
      answer.code = NUM_W'(((n / TILES_PER_ROW) << 4) | (n % TILES_PER_ROW + COL_OFFSET));
      answer.seen = overflow_sticky;
      return answer;
   endfunction

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // gap after a request beat; occasional runs of back-to-back beats
   function automatic int unsigned next_req_gap();
      if (req_steady_left > 0) begin
         req_steady_left--;
         return 0;
      end
      if ($urandom_range(0, 99) < 4) begin
         req_steady_left = 30;
         return 0;
      end
      if ($urandom_range(0, 99) < 45) return 0;
      return idle_length();
   endfunction

   function automatic tile_type make_random_tile();
      tile_type tile;
      for (int w = 0; w < TILE_W / 32; w++) tile[32*w +: 32] = $urandom;
      return tile;
   endfunction

   // mostly repeats and near misses of earlier tiles, some fresh and sparse ones
   function automatic tile_type pick_random_tile();
      tile_type    tile;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30 || tile_pool.size() == 0) begin
         tile = make_random_tile();
      end else if (r < 75) begin
         tile = tile_pool[$urandom_range(0, tile_pool.size() - 1)];
      end else if (r < 88) begin
         tile = tile_pool[$urandom_range(0, tile_pool.size() - 1)];
         tile[$urandom_range(0, TILE_W - 1)] ^= 1'b1;
      end else begin
         tile = '0;
         tile[4*$urandom_range(0, 15) +: 4] = 4'($urandom_range(1, 15));
      end
      return tile;
   endfunction

   function automatic void queue_tile(input tile_type tile);
      tiles_pending.push_back(tile);
      tile_pool.push_back(tile);
      tiles_issued++;
   endfunction

   task automatic report_field(input string field, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // one register access: setup phase, then access phase until pready
   task automatic tile_limit_access(input bit is_write, input logic [CSR_DATA_W-1:0] wdata,
                                    output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_tile_limit();
      logic [CSR_DATA_W-1:0] rdata;
      tile_limit_access(1'b0, '0, rdata);
      report_field("tile_limit readback", limit_now, rdata);
   endtask

   task automatic set_tile_limit(input logic [NUM_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      tile_limit_access(1'b1, CSR_DATA_W'(value), rdata);
      limit_now = value;
      check_tile_limit();
   endtask

   // wait until every queued tile is accepted and answered
   task automatic wait_drained();
      do @(posedge clock); while (tiles_accepted != tiles_issued || expected_answers.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: predict on each accepted beat, then offer the next tile.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_answers.push_back(lookup_tile(req_tdata));
            tiles_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_tvalid <= 1'b0;
            end else if (tiles_pending.size() != 0) begin
               req_tdata <= tiles_pending.pop_front();
               req_tvalid <= 1'b1;
               req_gap_left = next_req_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each beat with the oldest prediction, drive tready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            answer_seen = tile_answer_type'(rsp_tdata[16:0]);
            if (expected_answers.size() == 0) begin
               $display("%0t ns: result beat with no tile outstanding, expected none, actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               answer_due = expected_answers.pop_front();
               report_field("tile_code", answer_due.code, answer_seen.code);
               report_field("tile_number", answer_due.number, answer_seen.number);
               report_field("is_new", answer_due.is_new, answer_seen.is_new);
               report_field("overflowed_now", answer_due.overflowed, answer_seen.overflowed);
               report_field("overflow_seen", answer_due.seen, answer_seen.seen);
            end
            answers_checked++;
         end
         // one long hold so the input side backs up
         if (answers_checked == LONG_HOLD_AT && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_hold_left = LONG_HOLD_CYCLES;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_steady_left > 0) rsp_steady_left--;
            else if ($urandom_range(0, 99) < 5) rsp_steady_left = 40;
            else if ($urandom_range(0, 99) < 20) rsp_hold_left = idle_length();
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      tile_type         tile;
      tile_type         kept;
      logic [NUM_W-1:0] random_limits [5];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      check_tile_limit();

      // reset limit: zero and all-ones tiles, their repeats, field extremes
      queue_tile('0);
      queue_tile('1);
      queue_tile('0);
      queue_tile('1);
      for (int k = 0; k < 4; k++) begin
         tile = '0;
         tile[64*k +: 64] = '1;
         queue_tile(tile);
      end
      for (int k = 0; k < 4; k++) begin
         tile = '0;
         tile[64*k] = 1'b1;
         queue_tile(tile);
      end
      queue_tile(tile);
      wait_drained();

      // limit below the fill count: stored tiles still match, new ones overflow
      set_tile_limit(NUM_W'(1));
      queue_tile(make_random_tile());
      tile = '0;
      tile[64] = 1'b1;
      queue_tile(tile);
      queue_tile('0);
      wait_drained();

      // limit of zero
      set_tile_limit('0);
      queue_tile(make_random_tile());
      queue_tile('1);
      wait_drained();

      // fill up to the limit, crossing into the second display row
      set_tile_limit(NUM_W'(13));
      queue_tile(make_random_tile());
      kept = make_random_tile();
      queue_tile(kept);
      queue_tile(make_random_tile());
      queue_tile(make_random_tile());
      queue_tile(kept);
      wait_drained();

      // random phases; limits above the table size are capped
      random_limits = '{NUM_W'(40), NUM_W'(127), NUM_W'($urandom_range(0, 127)),
                        NUM_W'(96), NUM_W'(127)};
      foreach (random_limits[p]) begin
         set_tile_limit(random_limits[p]);
         for (int i = 0; i < RANDOM_PHASE_TILES; i++) queue_tile(pick_random_tile());
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[tile_dedup_dictionary.f]
+incdir+hw/rtl
hw/rtl/tdd_pkg.sv
hw/rtl/tdd_front.sv
hw/rtl/tdd_search.sv
hw/rtl/tile_dedup_dictionary.sv
test/tile_dedup_dictionary_test.sv
